### sv/tlb_page_table_translator_macros.svh
// Assertion helpers for the address translator checks.
// Both sample on the rising edge of clock.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_MACROS_SVH

// Same-cycle implication, ignored while reset is high
`define TPT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, also checked across reset
`define TPT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tpt_pkg.sv
package tpt_pkg;

   localparam int ADDR_W  = 16;
   localparam int BYTE_W  = 8;
   localparam int COUNT_W = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // Translation result codes
   typedef enum logic [1:0] {
      OUT_TLB_HIT    = 2'd0,
      OUT_TABLE_HIT  = 2'd1,
      OUT_PAGE_FAULT = 2'd2
   } outcome_type;

endpackage

### sv/tlb_page_table_translator.sv
// Channel   Direction  Handshake             Payload
// req       in         req_valid/req_stall   req_logical_address
// rsp       out        rsp_valid/rsp_stall   frame, offset, physical address, outcome, totals
//
// One transaction per cycle is sustained while rsp_stall is low; each result passes through the
// lookup stage, which holds the registered page table read, and then the result register.
// After reset a clearing pass marks every page table entry
// invalid; req_stall stays high throughout.
// rsp_stall holds the result register and backs up into req_stall once the
// lookup stage is also full. PAGE_BYTES and PAGE_COUNT are powers of two.
module tlb_page_table_translator
   import tpt_pkg::*;
#(
   parameter int TLB_ENTRIES = 16,
   parameter int PAGE_COUNT  = 256,
   parameter int PAGE_BYTES  = 256,
   parameter int FRAME_COUNT = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ADDR_W-1:0]  req_logical_address,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_frame_number,
   output logic [BYTE_W-1:0]  rsp_page_offset,
   output logic [ADDR_W-1:0]  rsp_physical_address,
   output logic [1:0]         rsp_outcome,
   output logic [COUNT_W-1:0] rsp_tlb_hit_total,
   output logic [COUNT_W-1:0] rsp_fault_total
);

   localparam int OFS_W   = $clog2(PAGE_BYTES);
   localparam int PAGE_W  = $clog2(PAGE_COUNT);
   localparam int FRAME_W = $clog2(FRAME_COUNT);

   // Clearing pass
   logic              clear_busy_ff;
   logic [PAGE_W-1:0] clear_idx_ff;

   // Lookup stage
   logic              s1_valid_ff, s1_valid_in;
   logic [PAGE_W-1:0] s1_page_ff;
   logic [OFS_W-1:0]  s1_offset_ff;
   logic [FRAME_W:0]  rd_data_ff;

   // Page table memory: valid bit over frame number
   logic [FRAME_W:0]  table_ff [PAGE_COUNT];
   logic              mem_we;
   logic [PAGE_W-1:0] mem_waddr;
   logic [FRAME_W:0]  mem_wdata;

   // TLB, front entry at index zero
   logic [PAGE_W-1:0]      tlb_tag_ff   [TLB_ENTRIES];
   logic [FRAME_W-1:0]     tlb_frame_ff [TLB_ENTRIES];
   logic [TLB_ENTRIES-1:0] tlb_valid_ff;

   // Translation state
   logic [FRAME_W-1:0] next_frame_ff, next_frame_in;
   logic [COUNT_W-1:0] hit_count_ff, hit_count_in;
   logic [COUNT_W-1:0] fault_count_ff, fault_count_in;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_frame_ff;
   logic [BYTE_W-1:0]  rsp_offset_ff;
   logic [ADDR_W-1:0]  rsp_phys_ff;
   outcome_type        rsp_outcome_ff;

   logic               req_accept;
   logic               s1_adv;
   logic [PAGE_W-1:0]  req_page;
   logic [31:0]        req_quot_wide;
   logic               tlb_hit;
   logic [FRAME_W-1:0] tlb_hit_frame;
   logic [FRAME_W-1:0] frame_sel;
   outcome_type        outcome_sel;
   logic               is_fault;
   logic [31:0]        frame_wide;
   logic [31:0]        offset_wide;
   logic [31:0]        phys_wide;

   // Handshake control
   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = clear_busy_ff || (s1_valid_ff && !s1_adv);
   assign req_accept = req_valid && !req_stall;

   // Split the address into page and offset
   assign req_quot_wide = 32'(req_logical_address >> OFS_W);
   assign req_page      = req_quot_wide[PAGE_W-1:0];

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = s1_adv || (rsp_valid_ff && rsp_stall);
   end

   // Run the clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clear_busy_ff <= 1'b1;
         clear_idx_ff  <= '0;
      end else if (clear_busy_ff) begin
         clear_idx_ff <= clear_idx_ff + 1'b1;
         if (clear_idx_ff == PAGE_W'(PAGE_COUNT - 1)) begin
            clear_busy_ff <= 1'b0;
         end
      end
   end

   // Capture the transaction into the lookup stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_accept) begin
         s1_page_ff   <= req_page;
         s1_offset_ff <= req_logical_address[OFS_W-1:0];
      end
   end

   // Page table port: one write, one registered read. A read that meets a write to
   // the same page returns stale data, but that page then sits at the TLB front and
   // the stale entry is never used.
   assign mem_we    = clear_busy_ff || (s1_adv && is_fault);
   assign mem_waddr = clear_busy_ff ? clear_idx_ff : s1_page_ff;
   assign mem_wdata = clear_busy_ff ? '0 : {1'b1, next_frame_ff};

   always_ff @(posedge clock) begin
      if (mem_we) begin
         table_ff[mem_waddr] <= mem_wdata;
      end
      if (req_accept) begin
         rd_data_ff <= table_ff[req_page];
      end
   end

   // Match the page in the TLB, nearest the front wins
   always_comb begin
      tlb_hit       = 1'b0;
      tlb_hit_frame = '0;
      for (int k = TLB_ENTRIES - 1; k >= 0; k--) begin
         if (tlb_valid_ff[k] && (tlb_tag_ff[k] == s1_page_ff)) begin
            tlb_hit       = 1'b1;
            tlb_hit_frame = tlb_frame_ff[k];
         end
      end
   end

   // Resolve the frame and update the counters
   always_comb begin
      next_frame_in  = next_frame_ff;
      hit_count_in   = hit_count_ff;
      fault_count_in = fault_count_ff;
      is_fault       = 1'b0;
      if (tlb_hit) begin
         outcome_sel = OUT_TLB_HIT;
         frame_sel   = tlb_hit_frame;
         if (hit_count_ff != COUNT_MAX) begin
            hit_count_in = hit_count_ff + 1'b1;
         end
      end else if (rd_data_ff[FRAME_W]) begin
         outcome_sel = OUT_TABLE_HIT;
         frame_sel   = rd_data_ff[FRAME_W-1:0];
      end else begin
         outcome_sel = OUT_PAGE_FAULT;
         frame_sel   = next_frame_ff;
         is_fault    = 1'b1;
         if (next_frame_ff == FRAME_W'(FRAME_COUNT - 1)) begin
            next_frame_in = '0;
         end else begin
            next_frame_in = next_frame_ff + 1'b1;
         end
         if (fault_count_ff != COUNT_MAX) begin
            fault_count_in = fault_count_ff + 1'b1;
         end
      end
   end

   // Form the physical address
   assign frame_wide  = 32'(frame_sel);
   assign offset_wide = 32'(s1_offset_ff);
   assign phys_wide   = (frame_wide << OFS_W) | offset_wide;

   // Advance translation state and push the TLB on a miss
   always_ff @(posedge clock) begin
      if (reset) begin
         tlb_valid_ff   <= '0;
         next_frame_ff  <= '0;
         hit_count_ff   <= '0;
         fault_count_ff <= '0;
      end else if (s1_adv) begin
         next_frame_ff  <= next_frame_in;
         hit_count_ff   <= hit_count_in;
         fault_count_ff <= fault_count_in;
         if (!tlb_hit) begin
            for (int k = TLB_ENTRIES - 1; k >= 1; k--) begin
               tlb_valid_ff[k] <= tlb_valid_ff[k-1];
            end
            tlb_valid_ff[0] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv && !tlb_hit) begin
         for (int k = TLB_ENTRIES - 1; k >= 1; k--) begin
            tlb_tag_ff[k]   <= tlb_tag_ff[k-1];
            tlb_frame_ff[k] <= tlb_frame_ff[k-1];
         end
         tlb_tag_ff[0]   <= s1_page_ff;
         tlb_frame_ff[0] <= frame_sel;
      end
   end

   // Load the result register, hold it while stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (s1_adv) begin
         rsp_frame_ff   <= frame_wide[BYTE_W-1:0];
         rsp_offset_ff  <= offset_wide[BYTE_W-1:0];
         rsp_phys_ff    <= phys_wide[ADDR_W-1:0];
         rsp_outcome_ff <= outcome_sel;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_frame_number     = rsp_frame_ff;
   assign rsp_page_offset      = rsp_offset_ff;
   assign rsp_physical_address = rsp_phys_ff;
   assign rsp_outcome          = rsp_outcome_ff;
   assign rsp_tlb_hit_total    = hit_count_ff;
   assign rsp_fault_total      = fault_count_ff;

endmodule

### sv/tpt_checker.sv
`include "tlb_page_table_translator_macros.svh"

module tpt_checker
   import tpt_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic [ADDR_W-1:0]  req_logical_address,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [BYTE_W-1:0]  rsp_frame_number,
   input logic [BYTE_W-1:0]  rsp_page_offset,
   input logic [ADDR_W-1:0]  rsp_physical_address,
   input logic [1:0]         rsp_outcome,
   input logic [COUNT_W-1:0] rsp_tlb_hit_total,
   input logic [COUNT_W-1:0] rsp_fault_total
);

   // Hold a stalled result transaction
   `TPT_ASSERT_NEXT(a_rsp_hold, !reset && rsp_valid && rsp_stall, reset || (rsp_valid && $stable(rsp_physical_address) && $stable(rsp_outcome)), "stalled result changed")

   // The clearing pass blocks requests right after reset
   `TPT_ASSERT_NEXT(a_clear_stall, reset, req_stall && !rsp_valid, "request open during clearing pass")

   // A TLB hit is already counted in the hit total
   `TPT_ASSERT_NOW(a_hit_counted, rsp_valid && (rsp_outcome == OUT_TLB_HIT), rsp_tlb_hit_total != '0, "TLB hit not counted")

   // A page fault is already counted in the fault total
   `TPT_ASSERT_NOW(a_fault_counted, rsp_valid && (rsp_outcome == OUT_PAGE_FAULT), rsp_fault_total != '0, "page fault not counted")

endmodule

bind tlb_page_table_translator tpt_checker u_tpt_checker (.*);
